### hw/rtl/ictd_pkg.sv
// shared widths, constants and types of the interval counter tick delta block
package ictd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DELTA_W = 17;
   localparam int INCR_W = 21;
   localparam int TOTAL_W = 64;
   localparam int JITTER_W = 32;
   localparam int JITTER_ROTATE = 7;

   localparam logic [SAMPLE_W-1:0] RELOAD_RESET = 16'd11932;
   localparam logic [INCR_W-1:0] NOMINAL_INCREMENT = 21'd100000;

   // delta * 10^7 / 1193182 = 8 * delta + delta * FRAC_NUM / FRAC_DEN
   localparam int WHOLE_SHIFT = 3;
   localparam int FRAC_NUM_W = 18;
   localparam int FRAC_DEN_W = 20;
   localparam logic [FRAC_NUM_W-1:0] FRAC_NUM = 18'd227272;
   localparam logic [FRAC_DEN_W-1:0] FRAC_DEN = 20'd596591;

   // floor(2^17 * FRAC_NUM / FRAC_DEN): estimate is low by at most one
   localparam int RECIP_W = 16;
   localparam int RECIP_SHIFT = 17;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 16'd49932;

   localparam int QUOT_W = 16;
   localparam int NUMER_W = DELTA_W + FRAC_NUM_W;

   typedef struct packed {
      logic [DELTA_W-1:0] delta;
      logic first;
      logic [TOTAL_W-1:0] total;
      logic [JITTER_W-1:0] jitter;
   } step_type;

endpackage

### hw/rtl/ictd_req_if.sv
// request channel: one latched counter sample per beat
interface ictd_req_if;
   logic valid;
   logic ready;
   logic [ictd_pkg::SAMPLE_W-1:0] counter_sample;

   modport source (output valid, output counter_sample, input ready);
   modport sink (input valid, input counter_sample, output ready);
endinterface

### hw/rtl/ictd_rsp_if.sv
// response channel: elapsed time result per beat
interface ictd_rsp_if;
   logic valid;
   logic ready;
   logic [ictd_pkg::INCR_W-1:0] increment_100ns;
   logic [ictd_pkg::TOTAL_W-1:0] elapsed_clocks;
   logic [ictd_pkg::JITTER_W-1:0] jitter_word;
   logic first_tick;

   modport source (output valid, output increment_100ns, output elapsed_clocks,
                   output jitter_word, output first_tick, input ready);
   modport sink (input valid, input increment_100ns, input elapsed_clocks,
                 input jitter_word, input first_tick, output ready);
endinterface

### hw/rtl/interval_counter_tick_delta_core.sv
// Elapsed-time tracker for a reloading down-counter sampled at each timer tick.
// req_chan carries one latched counter sample per beat; rsp_chan returns one
// result per request: time since the previous tick in 100 ns units, the 64-bit
// clock total, the jitter fold and a first-tick flag. csr_write_enable with
// csr_write_data sets the reload count (reset value 11932); the user must write
// it only while idle, and the block does not enforce this. Each request beat
// passes through registered stages before its response: the state update and
// delta, the reciprocal multiply, then the remainder correction of the divide
// by 1193182. One request is taken every cycle when the response side keeps
// up. Each stage holds a beat and lets a bubble collapse, so while the receiver
// stalls up to three beats are held and req_chan.ready drops only when all
// stages are full. Synchronous reset clears the tick state and all valid flags and
// restores the reload count to 11932; the first tick after reset reports 100000.
module interval_counter_tick_delta_core (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [ictd_pkg::SAMPLE_W-1:0] csr_write_data,
   ictd_req_if.sink req_chan,
   ictd_rsp_if.source rsp_chan
);

   logic req_beat;
   logic out_free, s2_free, s1_free;
   ictd_pkg::step_type step;

   logic s1_v_ff, s1_v_in;
   ictd_pkg::step_type s1_ff, s1_in;

   logic s2_v_ff, s2_v_in;
   logic [ictd_pkg::DELTA_W-1:0] s2_delta_ff, s2_delta_in;
   logic [ictd_pkg::QUOT_W-1:0] s2_quot_ff, s2_quot_in;
   logic [ictd_pkg::NUMER_W-1:0] s2_numer_ff, s2_numer_in;
   logic s2_first_ff, s2_first_in;
   logic [ictd_pkg::TOTAL_W-1:0] s2_total_ff, s2_total_in;
   logic [ictd_pkg::JITTER_W-1:0] s2_jitter_ff, s2_jitter_in;

   logic out_v_ff, out_v_in;
   logic [ictd_pkg::INCR_W-1:0] out_incr_ff, out_incr_in;
   logic [ictd_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;
   logic [ictd_pkg::JITTER_W-1:0] out_jitter_ff, out_jitter_in;
   logic out_first_ff, out_first_in;

   logic [ictd_pkg::DELTA_W+ictd_pkg::RECIP_W-1:0] recip_prod;
   logic [ictd_pkg::QUOT_W+ictd_pkg::FRAC_DEN_W-1:0] back_prod;
   logic [ictd_pkg::NUMER_W-1:0] remainder;
   logic bump;
   logic [ictd_pkg::INCR_W-1:0] scaled;

   ictd_track u_track (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .take(req_beat),
      .sample(req_chan.counter_sample),
      .step(step)
   );

   // stage handshake: a stage loads when it is empty or its beat moves on
   always_comb begin
      out_free = !out_v_ff || rsp_chan.ready;
      s2_free = !s2_v_ff || out_free;
      s1_free = !s1_v_ff || s2_free;
      req_chan.ready = s1_free;
      req_beat = req_chan.valid && s1_free;

      s1_v_in = req_beat || (s1_v_ff && !s2_free);
      s2_v_in = (s1_v_ff && s2_free) || (s2_v_ff && !out_free);
      out_v_in = (s2_v_ff && out_free) || (out_v_ff && !rsp_chan.ready);
   end

   // stage 2: reciprocal estimate of the fractional quotient and its numerator
   always_comb begin
      s1_in = req_beat ? step : s1_ff;
      recip_prod = (ictd_pkg::DELTA_W+ictd_pkg::RECIP_W)'(s1_ff.delta)
                 * (ictd_pkg::DELTA_W+ictd_pkg::RECIP_W)'(ictd_pkg::RECIP_MULT);
      if (s1_v_ff && s2_free) begin
         s2_delta_in = s1_ff.delta;
         s2_quot_in = recip_prod[ictd_pkg::DELTA_W+ictd_pkg::RECIP_W-1:ictd_pkg::RECIP_SHIFT];
         s2_numer_in = ictd_pkg::NUMER_W'(s1_ff.delta) * ictd_pkg::NUMER_W'(ictd_pkg::FRAC_NUM);
         s2_first_in = s1_ff.first;
         s2_total_in = s1_ff.total;
         s2_jitter_in = s1_ff.jitter;
      end else begin
         s2_delta_in = s2_delta_ff;
         s2_quot_in = s2_quot_ff;
         s2_numer_in = s2_numer_ff;
         s2_first_in = s2_first_ff;
         s2_total_in = s2_total_ff;
         s2_jitter_in = s2_jitter_ff;
      end
   end

   // stage 3: estimate is low by at most one, the remainder decides
   always_comb begin
      back_prod = (ictd_pkg::QUOT_W+ictd_pkg::FRAC_DEN_W)'(s2_quot_ff)
                * (ictd_pkg::QUOT_W+ictd_pkg::FRAC_DEN_W)'(ictd_pkg::FRAC_DEN);
      remainder = s2_numer_ff - back_prod[ictd_pkg::NUMER_W-1:0];
      bump = remainder >= ictd_pkg::NUMER_W'(ictd_pkg::FRAC_DEN);
      scaled = (ictd_pkg::INCR_W'(s2_delta_ff) << ictd_pkg::WHOLE_SHIFT)
             + ictd_pkg::INCR_W'(s2_quot_ff) + ictd_pkg::INCR_W'(bump);
      if (s2_v_ff && out_free) begin
         out_incr_in = s2_first_ff ? ictd_pkg::NOMINAL_INCREMENT : scaled;
         out_total_in = s2_total_ff;
         out_jitter_in = s2_jitter_ff;
         out_first_in = s2_first_ff;
      end else begin
         out_incr_in = out_incr_ff;
         out_total_in = out_total_ff;
         out_jitter_in = out_jitter_ff;
         out_first_in = out_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_delta_ff <= s2_delta_in;
      s2_quot_ff <= s2_quot_in;
      s2_numer_ff <= s2_numer_in;
      s2_first_ff <= s2_first_in;
      s2_total_ff <= s2_total_in;
      s2_jitter_ff <= s2_jitter_in;
      out_incr_ff <= out_incr_in;
      out_total_ff <= out_total_in;
      out_jitter_ff <= out_jitter_in;
      out_first_ff <= out_first_in;
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.increment_100ns = out_incr_ff;
   assign rsp_chan.elapsed_clocks = out_total_ff;
   assign rsp_chan.jitter_word = out_jitter_ff;
   assign rsp_chan.first_tick = out_first_ff;

   // reciprocal estimate never misses by more than one step
   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> remainder < (ictd_pkg::NUMER_W'(ictd_pkg::FRAC_DEN)
                             + ictd_pkg::NUMER_W'(ictd_pkg::FRAC_DEN)))
      else $error("quotient estimate out of correction range");

   // a full pipe behind a stalled receiver takes no beat
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && out_v_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken with every stage full");

   // the increment stays at or below 1100000
   a_incr_bound: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> out_incr_ff <= ictd_pkg::INCR_W'(1100000))
      else $error("increment beyond bound");

   // a beat in stage one moves on once the stage behind it is free
   a_s1_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_free) |=> s2_v_ff)
      else $error("stage one beat lost");

   // no beat shows up out of an empty pipe
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!s1_v_ff && !s2_v_ff && !out_v_ff) |=> !out_v_ff)
      else $error("response without request");

endmodule

### hw/rtl/ictd_track.sv
// tick state: previous sample, wrap undo, clock total and jitter fold
module ictd_track (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [ictd_pkg::SAMPLE_W-1:0] csr_write_data,
   input  logic take,
   input  logic [ictd_pkg::SAMPLE_W-1:0] sample,
   output ictd_pkg::step_type step
);

   logic [ictd_pkg::SAMPLE_W-1:0] reload_ff, reload_in;
   logic [ictd_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic started_ff, started_in;
   logic [ictd_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [ictd_pkg::JITTER_W-1:0] fold_ff, fold_in;

   logic [ictd_pkg::DELTA_W-1:0] wrap_sum;
   logic [ictd_pkg::DELTA_W-1:0] sample_ext;
   logic [ictd_pkg::DELTA_W-1:0] delta;
   logic [ictd_pkg::JITTER_W-1:0] fold_next;
   logic [ictd_pkg::TOTAL_W-1:0] total_next;

   always_comb begin
      sample_ext = ictd_pkg::DELTA_W'(sample);
      wrap_sum = ictd_pkg::DELTA_W'(prev_ff) + ictd_pkg::DELTA_W'(reload_ff);
      if (sample <= prev_ff) begin
         delta = ictd_pkg::DELTA_W'(prev_ff) - sample_ext;
      end else if (wrap_sum >= sample_ext) begin
         delta = wrap_sum - sample_ext;
      end else begin
         // sample beyond the reload value
         delta = '0;
      end
      fold_next = {fold_ff[ictd_pkg::JITTER_W-ictd_pkg::JITTER_ROTATE-1:0],
                   fold_ff[ictd_pkg::JITTER_W-1:ictd_pkg::JITTER_W-ictd_pkg::JITTER_ROTATE]}
                  ^ ictd_pkg::JITTER_W'(sample);
      total_next = started_ff ? total_ff + ictd_pkg::TOTAL_W'(delta) : total_ff;

      step.delta = delta;
      step.first = !started_ff;
      step.total = total_next;
      step.jitter = fold_next;

      reload_in = csr_write_enable ? csr_write_data : reload_ff;
      prev_in = take ? sample : prev_ff;
      started_in = started_ff || take;
      total_in = take ? total_next : total_ff;
      fold_in = take ? fold_next : fold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= ictd_pkg::RELOAD_RESET;
         prev_ff <= '0;
         started_ff <= 1'b0;
         total_ff <= '0;
         fold_ff <= '0;
      end else begin
         reload_ff <= reload_in;
         prev_ff <= prev_in;
         started_ff <= started_in;
         total_ff <= total_in;
         fold_ff <= fold_in;
      end
   end

endmodule
